// ===== rtl/core/esd_pkg.sv =====
// Shared types and character constants for the escape sequence decoder.
`timescale 1ns / 1ps

package esd_pkg;

   // Field widths
   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 9;
   localparam int DIGIT_W = 2;

   // Result queue depth; must be at least 3 so one-per-cycle flow survives a two-result item
   localparam int QUEUE_DEPTH = 3;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_BSLASH  = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_CARET   = 8'h5E;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_ESCAPE  = 8'h1B;
   localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CH_DIGIT_7 = 8'h37;
   localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_B    = 8'h42;
   localparam logic [CHAR_W-1:0] CH_UP_E    = 8'h45;
   localparam logic [CHAR_W-1:0] CH_UP_F    = 8'h46;
   localparam logic [CHAR_W-1:0] CH_UP_N    = 8'h4E;
   localparam logic [CHAR_W-1:0] CH_UP_R    = 8'h52;
   localparam logic [CHAR_W-1:0] CH_UP_S    = 8'h53;
   localparam logic [CHAR_W-1:0] CH_UP_T    = 8'h54;
   localparam logic [CHAR_W-1:0] CH_UP_X    = 8'h58;
   localparam logic [CHAR_W-1:0] CH_UP_Z    = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LO_A    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LO_Z    = 8'h7A;

   // Control codes produced by the letter escapes
   localparam logic [CHAR_W-1:0] CODE_BS  = 8'h08;
   localparam logic [CHAR_W-1:0] CODE_TAB = 8'h09;
   localparam logic [CHAR_W-1:0] CODE_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] CODE_FF  = 8'h0C;
   localparam logic [CHAR_W-1:0] CODE_CR  = 8'h0D;

   // Offsets
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;
   localparam logic [CHAR_W-1:0] CTRL_OFFSET  = 8'h40;
   localparam logic [3:0]        HEX_LETTER_ADJ = 4'd9;

   // Number of digits that closes a run
   localparam logic [DIGIT_W-1:0] HEX_DIGITS = 2'd2;
   localparam logic [DIGIT_W-1:0] OCT_DIGITS = 2'd3;

   // Decoder mode, one-hot
   typedef enum logic [4:0] {
      MODE_IDLE  = 5'b00001,
      MODE_ESC   = 5'b00010,
      MODE_CARET = 5'b00100,
      MODE_HEX   = 5'b01000,
      MODE_OCT   = 5'b10000
   } mode_type;

   // One input transaction
   typedef struct packed {
      logic [CHAR_W-1:0] char_in;
      logic              end_of_string;
   } item_type;

   // Results of one decode step (count is 0, 1 or 2)
   typedef struct packed {
      logic [1:0]         count;
      logic [VALUE_W-1:0] value0;
      logic [VALUE_W-1:0] value1;
   } result_type;

   // One queued output transaction
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } entry_type;

endpackage

// ===== rtl/core/esd_decode.sv =====
// Escape decoding state machine: one input character per step, up to two results.
`timescale 1ns / 1ps

module esd_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  esd_pkg::item_type   item,
   output esd_pkg::result_type result
);

   esd_pkg::mode_type                   mode_ff, mode_in;
   logic [esd_pkg::VALUE_W-1:0]         accum_ff, accum_in;
   logic [esd_pkg::DIGIT_W-1:0]         digits_ff, digits_in;

   logic [esd_pkg::CHAR_W-1:0]          c;
   logic [esd_pkg::CHAR_W-1:0]          up;
   logic                                is_oct;
   logic                                is_dec;
   logic                                is_hex;
   logic [3:0]                          hex_v;
   logic [esd_pkg::VALUE_W-1:0]         acc_hex;
   logic [esd_pkg::VALUE_W-1:0]         acc_oct;
   logic [esd_pkg::DIGIT_W-1:0]         digits_inc;

   logic                                e0_en, e1_en, f_en;
   logic [esd_pkg::VALUE_W-1:0]         e0_v, e1_v, f_v;

   // Character classification
   always_comb begin
      c       = item.char_in;
      up      = (c inside {[esd_pkg::CH_LO_A:esd_pkg::CH_LO_Z]}) ?
                c - esd_pkg::CASE_OFFSET : c;
      is_oct  = c inside {[esd_pkg::CH_DIGIT_0:esd_pkg::CH_DIGIT_7]};
      is_dec  = c inside {[esd_pkg::CH_DIGIT_0:esd_pkg::CH_DIGIT_9]};
      is_hex  = is_dec || (up inside {[esd_pkg::CH_UP_A:esd_pkg::CH_UP_F]});
      hex_v   = is_dec ? c[3:0] : up[3:0] + esd_pkg::HEX_LETTER_ADJ;
      acc_hex = {accum_ff[4:0], hex_v};
      acc_oct = {accum_ff[5:0], c[2:0]};
      digits_inc = digits_ff + 2'd1;
   end

   // Next state and emitted values
   always_comb begin
      mode_in   = esd_pkg::MODE_IDLE;
      accum_in  = '0;
      digits_in = '0;
      e0_en     = 1'b0;
      e0_v      = {1'b0, c};
      e1_en     = 1'b0;
      e1_v      = {1'b0, c};

      case (mode_ff)
         esd_pkg::MODE_ESC: begin
            e0_en = 1'b1;
            case (up)
               esd_pkg::CH_UP_B: e0_v = {1'b0, esd_pkg::CODE_BS};
               esd_pkg::CH_UP_F: e0_v = {1'b0, esd_pkg::CODE_FF};
               esd_pkg::CH_UP_T: e0_v = {1'b0, esd_pkg::CODE_TAB};
               esd_pkg::CH_UP_N: e0_v = {1'b0, esd_pkg::CODE_LF};
               esd_pkg::CH_UP_R: e0_v = {1'b0, esd_pkg::CODE_CR};
               esd_pkg::CH_UP_S: e0_v = {1'b0, esd_pkg::CH_SPACE};
               esd_pkg::CH_UP_E: e0_v = {1'b0, esd_pkg::CH_ESCAPE};
               esd_pkg::CH_CARET: begin
                  e0_en   = 1'b0;
                  mode_in = esd_pkg::MODE_CARET;
               end
               esd_pkg::CH_UP_X: begin
                  e0_en   = 1'b0;
                  mode_in = esd_pkg::MODE_HEX;
               end
               default: begin
                  // first octal digit opens a run; anything else stands for itself
                  if (is_oct) begin
                     e0_en     = 1'b0;
                     mode_in   = esd_pkg::MODE_OCT;
                     accum_in  = {6'b0, c[2:0]};
                     digits_in = 2'd1;
                  end
               end
            endcase
         end
         esd_pkg::MODE_CARET: begin
            e0_en = 1'b1;
            if (up inside {[esd_pkg::CH_UP_A:esd_pkg::CH_UP_Z]}) begin
               e0_v = {1'b0, up - esd_pkg::CTRL_OFFSET};
            end else if (c >= esd_pkg::CH_SPACE) begin
               e0_v = {1'b0, c - esd_pkg::CH_SPACE};
            end
         end
         esd_pkg::MODE_HEX: begin
            if (is_hex) begin
               if (digits_inc >= esd_pkg::HEX_DIGITS) begin
                  e0_en = 1'b1;
                  e0_v  = acc_hex;
               end else begin
                  mode_in   = esd_pkg::MODE_HEX;
                  accum_in  = acc_hex;
                  digits_in = digits_inc;
               end
            end else begin
               // terminator: emit run value, then decode the character itself
               e0_en = 1'b1;
               e0_v  = accum_ff;
               if (c == esd_pkg::CH_BSLASH) begin
                  mode_in = esd_pkg::MODE_ESC;
               end else begin
                  e1_en = 1'b1;
               end
            end
         end
         esd_pkg::MODE_OCT: begin
            if (is_oct) begin
               if (digits_inc >= esd_pkg::OCT_DIGITS) begin
                  e0_en = 1'b1;
                  e0_v  = acc_oct;
               end else begin
                  mode_in   = esd_pkg::MODE_OCT;
                  accum_in  = acc_oct;
                  digits_in = digits_inc;
               end
            end else begin
               e0_en = 1'b1;
               e0_v  = accum_ff;
               if (c == esd_pkg::CH_BSLASH) begin
                  mode_in = esd_pkg::MODE_ESC;
               end else begin
                  e1_en = 1'b1;
               end
            end
         end
         default: begin
            // idle: plain character or start of escape
            if (c == esd_pkg::CH_BSLASH) begin
               mode_in = esd_pkg::MODE_ESC;
            end else begin
               e0_en = 1'b1;
            end
         end
      endcase

      // End of string flushes whatever is still pending
      f_en = item.end_of_string && (mode_in != esd_pkg::MODE_IDLE);
      f_v  = (mode_in == esd_pkg::MODE_HEX || mode_in == esd_pkg::MODE_OCT) ? accum_in : '0;
      if (f_en) begin
         mode_in   = esd_pkg::MODE_IDLE;
         accum_in  = '0;
         digits_in = '0;
      end

      // Pack up to two results in order
      if (e0_en) begin
         result.value0 = e0_v;
         result.value1 = e1_en ? e1_v : f_v;
         result.count  = 2'd1 + {1'b0, e1_en} + {1'b0, f_en};
      end else begin
         result.value0 = f_v;
         result.value1 = f_v;
         result.count  = {1'b0, f_en};
      end
   end

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= esd_pkg::MODE_IDLE;
         accum_ff  <= '0;
         digits_ff <= '0;
      end else if (step) begin
         mode_ff   <= mode_in;
         accum_ff  <= accum_in;
         digits_ff <= digits_in;
      end
   end

endmodule

// ===== rtl/core/escape_sequence_decoder_unit.sv =====
// Top level: input register, escape decoder and result queue.
// The input register holds an accepted transaction; it is decoded combinationally and its
//   results are written into the result queue, whose head is offered on the response port.
// Throughput: one input transaction per cycle while the result queue has room for both
//   possible results; items that yield two results are absorbed by a QUEUE_DEPTH-entry queue.
// Reset (synchronous, active high) empties the input register and the queue and returns
//   the decoder to idle with a cleared accumulator and digit count.
`timescale 1ns / 1ps

module escape_sequence_decoder_unit #(
   parameter int QUEUE_DEPTH = esd_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [esd_pkg::CHAR_W-1:0]   req_char_in,
   input  logic                         req_end_of_string,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [esd_pkg::VALUE_W-1:0]  rsp_decoded,
   output logic                         rsp_last_of_run
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);

   logic                  in_valid_ff;
   esd_pkg::item_type     item_ff;
   esd_pkg::result_type   res;
   esd_pkg::entry_type    q_ff [QUEUE_DEPTH];
   esd_pkg::entry_type    q_in [QUEUE_DEPTH];
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         base;
   logic                  pop;
   logic                  advance;

   // Handshake and queue room: decode only when both results would fit
   always_comb begin
      pop       = (count_ff != '0) && !rsp_stall;
      base      = count_ff - CW'(pop);
      advance   = in_valid_ff && (({1'b0, base} + (CW+1)'(2)) <= (CW+1)'(QUEUE_DEPTH));
      req_stall = in_valid_ff && !advance;
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.char_in       <= req_char_in;
         item_ff.end_of_string <= req_end_of_string;
      end
   end

   esd_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .result (res)
   );

   // Result queue: shift on pop, append decoded results behind the survivors
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         q_in[i] = pop ? q_ff[i+1] : q_ff[i];
      end
      q_in[QUEUE_DEPTH-1] = q_ff[QUEUE_DEPTH-1];
      if (advance) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (res.count != 2'd0 && i == int'(base)) begin
               q_in[i].value = res.value0;
               q_in[i].last  = (res.count == 2'd1);
            end
            if (res.count == 2'd2 && i == int'(base) + 1) begin
               q_in[i].value = res.value1;
               q_in[i].last  = 1'b1;
            end
         end
      end
      count_in = base + (advance ? CW'(res.count) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign rsp_valid       = (count_ff != '0);
   assign rsp_decoded     = q_ff[0].value;
   assign rsp_last_of_run = q_ff[0].last;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("result queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      advance |-> (int'(base) + int'(res.count)) <= QUEUE_DEPTH)
      else $error("decode step overflows result queue");

   a_tail_is_last: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> q_ff[IW'(count_ff - CW'(1))].last)
      else $error("newest queued result does not close its transaction");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> count_ff >= CW'(QUEUE_DEPTH - 1))
      else $error("input stalled with room in the result queue");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (count_ff == '0) && !in_valid_ff)
      else $error("block not empty after reset");

endmodule
